### rtl/lgqg_pkg.sv
package lgqg_pkg;

  localparam int unsigned GradeW = 3;
  localparam int unsigned LevelW = 2;
  localparam int unsigned HoldW  = 8;
  localparam int unsigned IndexW = 3;
  localparam int unsigned DataW  = 8;

  typedef logic [GradeW-1:0] grade_t;
  typedef logic [LevelW-1:0] level_t;

  // configuration register indexes
  typedef enum logic [IndexW-1:0] {
    REG_CEILING         = 3'd0,
    REG_HOLD_SAMPLES    = 3'd1,
    REG_SINGLE_STEP     = 3'd2,
    REG_START_QUALITY   = 3'd3,
    REG_EXTERNAL_LOCK   = 3'd4
  } cfg_reg_t;

  // link grade codes
  localparam grade_t GRADE_UNKNOWN   = 3'd0;
  localparam grade_t GRADE_POOR      = 3'd1;
  localparam grade_t GRADE_FAIR      = 3'd2;
  localparam grade_t GRADE_GOOD      = 3'd3;
  localparam grade_t GRADE_EXCELLENT = 3'd4;

  // quality levels
  localparam level_t LEVEL_THUMB = 2'd0;
  localparam level_t LEVEL_LOW   = 2'd1;
  localparam level_t LEVEL_HD    = 2'd2;
  localparam level_t LEVEL_FHD   = 2'd3;

  // reset values
  localparam level_t            CEILING_RST = LEVEL_FHD;
  localparam logic [HoldW-1:0]  HOLD_RST    = 8'd3;
  localparam logic              STEP_RST    = 1'b1;
  localparam level_t            START_RST   = LEVEL_HD;
  localparam logic              LOCK_RST    = 1'b0;

  // grade to level, clamped to the ceiling
  function automatic level_t grade_level(grade_t grade, level_t ceiling);
    level_t lvl;
    unique case (grade)
      GRADE_POOR:      lvl = LEVEL_THUMB;
      GRADE_FAIR:      lvl = LEVEL_LOW;
      GRADE_GOOD:      lvl = LEVEL_HD;
      GRADE_EXCELLENT: lvl = LEVEL_FHD;
      default:         lvl = LEVEL_HD;
    endcase
    return (lvl > ceiling) ? ceiling : lvl;
  endfunction

endpackage

### rtl/lgqg_if.sv
interface lgqg_sample_if import lgqg_pkg::*; ();
  logic   valid;
  logic   ready;
  grade_t link_grade;

  modport source (output valid, output link_grade, input ready);
  modport sink (input valid, input link_grade, output ready);
endinterface

interface lgqg_result_if import lgqg_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t quality_level;
  logic   apply_change;

  modport source (output valid, output quality_level, output apply_change, input ready);
  modport sink (input valid, input quality_level, input apply_change, output ready);
endinterface

interface lgqg_cfg_if import lgqg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] index;
  logic [DataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/link_grade_quality_governor_core.sv
// link-grade quality governor
//
// sample channel: one link-grade beat per sample. result channel: one beat
// per sample carrying the current quality target and an apply flag that is
// high when the target moved on that sample and the external lock is off.
// cfg channel: register writes (index, data), always ready; write only while
// no sample is in flight.
//
// pipeline: a sample beat accepted into the input register moves on to the
// result register, which drives result valid. throughput is one sample per
// cycle while results are taken; the governor state updates in the cycle a
// sample moves from input to result register if no cfg write lands in it.
//
// when the receiver stalls, the result register holds its beat and the input
// register takes one more sample; sample ready then drops until the result
// is taken. ready is combinational from result ready.
//
// reset (rst, synchronous): pipeline empty, registers at their defaults
// (ceiling fhd, hold 3, single step on, target hd, lock off), hold count 0.
module link_grade_quality_governor_core import lgqg_pkg::*; #(
  parameter int unsigned HOLD_MAX = 255
) (
  input  logic         clk,
  input  logic         rst,
  lgqg_sample_if.sink  sample,
  lgqg_result_if.source result,
  lgqg_cfg_if.sink     cfg
);

  // hold counter wide enough to saturate at HOLD_MAX
  localparam int unsigned CntW = $clog2(HOLD_MAX + 1);
  // common width for the hold compare
  localparam int unsigned CmpW = (CntW > HoldW) ? CntW : HoldW;

  // configuration registers
  level_t            level_cap;
  logic [HoldW-1:0]  hold_samples;
  logic              single_step;
  logic              external_lock;

  // governor state
  level_t            current_level;
  level_t            pending_level;
  logic [CntW-1:0]   hold_count;

  level_t            current_level_next;
  level_t            pending_level_next;
  logic [CntW-1:0]   hold_count_next;
  logic              changed;

  // input register
  logic              in_valid;
  grade_t            grade;

  // result register
  logic              out_valid;
  level_t            out_level;
  logic              out_apply;

  logic              out_free;
  logic              advance;

  assign out_free     = !out_valid || result.ready;
  assign advance      = in_valid && out_free;
  assign sample.ready = !in_valid || out_free;
  assign cfg.ready    = 1'b1;

  assign result.valid         = out_valid;
  assign result.quality_level = out_level;
  assign result.apply_change  = out_apply;

  // one pass of the hysteresis rule on the registered grade
  always_comb begin
    level_t            lvl;
    logic [CntW-1:0]   cnt_inc;
    logic [HoldW-1:0]  need;
    level_t            step;

    lvl     = grade_level(grade, level_cap);
    cnt_inc = (hold_count == CntW'(HOLD_MAX)) ? hold_count : hold_count + 1'b1;
    need    = (hold_samples == '0) ? HoldW'(1) : hold_samples;
    step    = current_level + 1'b1;

    current_level_next = current_level;
    pending_level_next = pending_level;
    hold_count_next    = hold_count;
    changed            = 1'b0;

    priority if (grade == GRADE_UNKNOWN) begin
      // unknown grade drops any pending promotion
      hold_count_next    = '0;
      pending_level_next = current_level;
    end else if (lvl < current_level) begin
      // demotion is immediate
      current_level_next = lvl;
      pending_level_next = lvl;
      hold_count_next    = '0;
      changed            = 1'b1;
    end else if (lvl == current_level) begin
      hold_count_next    = '0;
      pending_level_next = current_level;
    end else begin
      // promotion candidate: count consecutive agreeing samples
      if (lvl == pending_level) begin
        hold_count_next = cnt_inc;
      end else begin
        pending_level_next = lvl;
        hold_count_next    = CntW'(1);
      end
      if (CmpW'(hold_count_next) >= CmpW'(need)) begin
        // commit; single step limits the climb to one level
        if (single_step && ({1'b0, pending_level_next} > ({1'b0, current_level} + 3'd1))) begin
          current_level_next = step;
        end else begin
          current_level_next = pending_level_next;
        end
        hold_count_next = '0;
        changed         = 1'b1;
      end
    end
  end

  // configuration and governor state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_cap       <= CEILING_RST;
      hold_samples    <= HOLD_RST;
      single_step     <= STEP_RST;
      external_lock   <= LOCK_RST;
      current_level   <= START_RST;
      pending_level   <= START_RST;
      hold_count      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CEILING:         level_cap       <= cfg.data[LevelW-1:0];
        REG_HOLD_SAMPLES:    hold_samples    <= cfg.data[HoldW-1:0];
        REG_SINGLE_STEP:     single_step     <= cfg.data[0];
        REG_START_QUALITY: begin
          // reload the target and drop any pending promotion
          current_level <= cfg.data[LevelW-1:0];
          pending_level <= cfg.data[LevelW-1:0];
          hold_count    <= '0;
        end
        REG_EXTERNAL_LOCK:   external_lock   <= cfg.data[0];
        default: ;
      endcase
    end else if (advance) begin
      current_level <= current_level_next;
      pending_level <= pending_level_next;
      hold_count    <= hold_count_next;
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      grade <= sample.link_grade;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= current_level_next;
      out_apply <= changed && !external_lock;
    end
  end

endmodule
